// ----- sv/time_ordered_event_queue_core_defines.svh -----
// Assertion macros for the time-ordered event queue core.
`ifndef TIME_ORDERED_EVENT_QUEUE_CORE_DEFINES_SVH
`define TIME_ORDERED_EVENT_QUEUE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define TOEQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Same-cycle implication.
`define TOEQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define TOEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TOEQ_ASSERT_ALWAYS(lbl, prop, msg)
`define TOEQ_ASSERT_IMPL(lbl, ante, cons, msg)
`define TOEQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- sv/toeq_pkg.sv -----
// Shared types and constants for the time-ordered event queue.
package toeq_pkg;

  localparam int DEFAULT_DEPTH = 16;
  localparam int TIME_W        = 48;
  localparam int CODE_W        = 8;
  localparam int STATUS_W      = 2;
  localparam int OCC_W         = 5;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef struct packed {
    logic [CODE_W-1:0] ev_purpose;
    logic [CODE_W-1:0] ev_type;
    logic [TIME_W-1:0] tstamp;
  } entry_t;

  // Broadcast to every cell in the chain.
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t ent;
  } ctrl_t;

endpackage

// ----- sv/time_ordered_event_queue_core.sv -----
// Top level of the time-ordered event queue: a chain of sorted slot cells.
//
// Usage:
//   Drive kind and the event fields, and pulse start. A command is taken at
//   a rising edge where start is high and busy is low; busy stays low, so a
//   command can be issued every cycle.
//   kind = insert: the event is placed after every stored event with an
//   equal or earlier time. kind = remove: the earliest event leaves.
//   Each command gives one result word, shown for exactly one cycle with
//   done high, in the cycle right after the command was taken, and the
//   block takes one command per cycle. This comes from every cell comparing
//   its own time to the broadcast time in parallel and loading its own, its
//   left neighbor's, its right neighbor's or the new entry at the same edge.
//   status reports a full queue on insert or an empty queue on remove; the
//   head fields are zero unless a remove succeeded. occupancy is the count
//   after the command, modulo 32.
//   The receiver cannot stall: a result not taken in its cycle is gone.
//   Reset (rst, synchronous) empties the queue and clears done; slot
//   contents are left as they are and are never read before being written.
module time_ordered_event_queue_core #(
  parameter int QUEUE_DEPTH = toeq_pkg::DEFAULT_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           kind,
  input  logic [toeq_pkg::CODE_W-1:0]    event_type,
  input  logic [toeq_pkg::CODE_W-1:0]    event_purpose,
  input  logic [toeq_pkg::TIME_W-1:0]    event_time,
  output logic                           done,
  output logic [toeq_pkg::STATUS_W-1:0]  status,
  output logic [toeq_pkg::CODE_W-1:0]    head_type,
  output logic [toeq_pkg::CODE_W-1:0]    head_purpose,
  output logic [toeq_pkg::TIME_W-1:0]    head_time,
  output logic [toeq_pkg::OCC_W-1:0]     occupancy
);

`include "time_ordered_event_queue_core_defines.svh"

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic             accept;
  logic             full;
  logic             empty;
  toeq_pkg::ctrl_t  ctrl;
  toeq_pkg::entry_t ent [QUEUE_DEPTH];
  logic             le  [QUEUE_DEPTH];

  // Every command completes in the cycle it is taken.
  assign busy   = 1'b0;
  assign accept = start && !busy && !rst;
  assign full   = (count == CW'(QUEUE_DEPTH));
  assign empty  = (count == '0);

  // Broadcast the command to all cells; drop rejected ones here.
  always_comb begin
    ctrl.ins                = accept && (kind == toeq_pkg::KIND_INSERT) && !full;
    ctrl.rem                = accept && (kind == toeq_pkg::KIND_REMOVE) && !empty;
    ctrl.ent.ev_type        = event_type;
    ctrl.ent.ev_purpose     = event_purpose;
    ctrl.ent.tstamp         = event_time;
  end

  always_comb begin
    count_next = count;
    if (ctrl.ins) begin
      count_next = count + CW'(1);
    end else if (ctrl.rem) begin
      count_next = count - CW'(1);
    end
  end

  // Slot chain: slot 0 is the head. Occupancy is a prefix set by count.
  // On insert a slot holds if its event is not later than the new one,
  // takes the new event if its left neighbor holds, else shifts right.
  // On remove every slot takes its right neighbor's entry.
  genvar i;
  generate
    for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic             prev_le_i;
      toeq_pkg::entry_t prev_ent_i;
      toeq_pkg::entry_t next_ent_i;

      if (i == 0) begin : g_first
        assign prev_le_i  = 1'b1;
        assign prev_ent_i = ctrl.ent;
      end else begin : g_mid
        assign prev_le_i  = le[i-1];
        assign prev_ent_i = ent[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
        assign next_ent_i = ent[i];
      end else begin : g_notlast
        assign next_ent_i = ent[i+1];
      end

      toeq_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .occupied (CW'(i) < count),
        .prev_le  (prev_le_i),
        .prev_ent (prev_ent_i),
        .next_ent (next_ent_i),
        .ent      (ent[i]),
        .le       (le[i])
      );
    end
  endgenerate

  // Hold the count and the done strobe; clear both at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  // Result word: head fields only on a successful remove.
  always_ff @(posedge clk) begin
    if (accept) begin
      occupancy    <= toeq_pkg::OCC_W'(count_next);
      head_type    <= '0;
      head_purpose <= '0;
      head_time    <= '0;
      if (kind == toeq_pkg::KIND_INSERT) begin
        status <= full ? toeq_pkg::ST_FULL : toeq_pkg::ST_DONE;
      end else if (empty) begin
        status <= toeq_pkg::ST_EMPTY;
      end else begin
        status       <= toeq_pkg::ST_DONE;
        head_type    <= ent[0].ev_type;
        head_purpose <= ent[0].ev_purpose;
        head_time    <= ent[0].tstamp;
      end
    end
  end

  // Count never exceeds the slot count.
  `TOEQ_ASSERT_ALWAYS(a_count_range, count <= CW'(QUEUE_DEPTH), "count above depth")
  // Every accepted command yields a result the next cycle.
  `TOEQ_ASSERT_NEXT(a_result_follows, accept, done, "missing result strobe")
  // A successful remove shrinks the count by one.
  `TOEQ_ASSERT_NEXT(a_remove_count, ctrl.rem, count == CW'($past(count) - CW'(1)), "remove count")
  // The two front slots stay in time order.
  `TOEQ_ASSERT_IMPL(a_head_sorted, count >= CW'(2), ent[0].tstamp <= ent[1].tstamp, "head order")

endmodule

// ----- sv/toeq_cell.sv -----
// One slot of the sorted queue: holds an entry and trades with its neighbors.
module toeq_cell (
  input  logic             clk,
  input  toeq_pkg::ctrl_t  ctrl,
  input  logic             occupied,
  input  logic             prev_le,
  input  toeq_pkg::entry_t prev_ent,
  input  toeq_pkg::entry_t next_ent,
  output toeq_pkg::entry_t ent,
  output logic             le
);

  // Stored event is not later than the incoming one: it stays put on insert.
  assign le = occupied && (ent.tstamp <= ctrl.ent.tstamp);

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (!le) begin
        ent <= prev_le ? ctrl.ent : prev_ent;
      end
    end else if (ctrl.rem) begin
      ent <= next_ent;
    end
  end

endmodule

// ----- bench/tb_time_ordered_event_queue_core.sv -----
// Self-checking testbench for the time-ordered event queue core.
module tb_time_ordered_event_queue_core;
  timeunit 1ns;
  timeprecision 1ps;

  import toeq_pkg::*;

  localparam int DEPTH        = DEFAULT_DEPTH;
  localparam int RANDOM_ITEMS = 1880;
  localparam int STALL_LIMIT  = 1000;
  localparam int REPORT_MAX   = 10;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // One result word as the block should show it.
  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [CODE_W-1:0]   ev_type;
    logic [CODE_W-1:0]   ev_purpose;
    logic [TIME_W-1:0]   tstamp;
    logic [OCC_W-1:0]    occupancy;
  } head_word_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic                kind;
  logic [CODE_W-1:0]   event_type;
  logic [CODE_W-1:0]   event_purpose;
  logic [TIME_W-1:0]   event_time;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic [CODE_W-1:0]   head_type;
  logic [CODE_W-1:0]   head_purpose;
  logic [TIME_W-1:0]   head_time;
  logic [OCC_W-1:0]    occupancy;

  // Our own sorted copy of the schedule, earliest event in slot 0.
  entry_t      sched_slots [DEPTH];
  int          sched_count;
  head_word_t  pending_heads [$];

  int          mismatch_count;
  int          idle_cycles;
  bit          gaps_on;
  logic [TIME_W-1:0] last_time;

  time_ordered_event_queue_core #(
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .event_type   (event_type),
    .event_purpose(event_purpose),
    .event_time   (event_time),
    .done         (done),
    .status       (status),
    .head_type    (head_type),
    .head_purpose (head_purpose),
    .head_time    (head_time),
    .occupancy    (occupancy)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one accepted word to the schedule copy and queue the word the
  // block must answer with in the following cycle.
  function automatic void schedule_word(logic k, logic [CODE_W-1:0] ty,
                                        logic [CODE_W-1:0] pu,
                                        logic [TIME_W-1:0] tm);
    head_word_t w;
    int pos;
    w.status     = ST_DONE;
    w.ev_type    = '0;
    w.ev_purpose = '0;
    w.tstamp     = '0;
    if (k == KIND_INSERT) begin
      if (sched_count >= DEPTH) begin
        // Full: drop the event, leave the schedule alone.
        w.status = ST_FULL;
      end else begin
        // Walk past every event at or before the new time, so equal
        // times leave in arrival order.
        pos = 0;
        while (pos < sched_count && sched_slots[pos].tstamp <= tm) pos++;
        for (int i = sched_count; i > pos; i--) sched_slots[i] = sched_slots[i-1];
        sched_slots[pos].tstamp     = tm;
        sched_slots[pos].ev_type    = ty;
        sched_slots[pos].ev_purpose = pu;
        sched_count++;
      end
    end else begin
      if (sched_count == 0) begin
        w.status = ST_EMPTY;
      end else begin
        // Pop the head and shift the rest forward.
        w.ev_type    = sched_slots[0].ev_type;
        w.ev_purpose = sched_slots[0].ev_purpose;
        w.tstamp     = sched_slots[0].tstamp;
        for (int i = 1; i < sched_count; i++) sched_slots[i-1] = sched_slots[i];
        sched_count--;
      end
    end
    w.occupancy = OCC_W'(sched_count);
    pending_heads.push_back(w);
  endfunction

  // Send one command word: random idle cycles first (unless gaps are off),
  // then hold start high until the block takes the word.
  task automatic issue_word(input logic k, input logic [CODE_W-1:0] ty,
                            input logic [CODE_W-1:0] pu,
                            input logic [TIME_W-1:0] tm);
    while (gaps_on && $urandom_range(0, 99) < 10) begin
      @(negedge clk);
      start <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    start         <= 1'b1;
    kind          <= k;
    event_type    <= ty;
    event_purpose <= pu;
    event_time    <= tm;
    do @(posedge clk); while (busy);
    schedule_word(k, ty, pu, tm);
  endtask

  // Pick a time: small values, full-range values, values near the top, or
  // a repeat of the last inserted time to build ties.
  function automatic logic [TIME_W-1:0] pick_time();
    logic [TIME_W-1:0] t;
    case ($urandom_range(0, 3))
      0:       t = TIME_W'($urandom_range(0, 3)) << 16;
      1:       t = {16'($urandom), 32'($urandom)};
      2:       t = TIME_MAX - TIME_W'($urandom_range(0, 2));
      default: t = last_time;
    endcase
    return t;
  endfunction

  // Remove on an empty queue, with the ignored event fields at both extremes.
  task automatic test_remove_empty();
    issue_word(KIND_REMOVE, '1, '1, TIME_MAX);
    issue_word(KIND_REMOVE, '0, '0, '0);
  endtask

  // Fill every slot with extreme times, ties and out-of-order arrivals, then
  // push one more insert against the full queue.
  task automatic test_fill_and_overflow();
    logic [TIME_W-1:0] fill_times [16] = '{
      48'h0, TIME_MAX, 48'd100 << 16, 48'd100 << 16,
      48'd100 << 16, 48'd50 << 16, 48'h8000_0000_0000, 48'h1,
      48'h7FFF_FFFF_FFFF, 48'd100 << 16, TIME_MAX, 48'h0,
      48'd200 << 16, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 48'h1
    };
    for (int i = 0; i < DEPTH; i++) begin
      issue_word(KIND_INSERT, CODE_W'(i * 17), CODE_W'(255 - i * 17),
                 fill_times[i % 16]);
    end
    issue_word(KIND_INSERT, 8'hA5, 8'h5A, 48'h0);
  endtask

  // Pull a few heads off: ties must come back in arrival order.
  task automatic test_drain_head();
    for (int i = 0; i < 6; i++) issue_word(KIND_REMOVE, 8'($urandom), 8'($urandom), '0);
  endtask

  // Bursts that lean toward insert or remove swing the queue between empty
  // and full; one long stretch runs with no gaps at all.
  task automatic test_random_traffic();
    int insert_pct;
    logic k;
    logic [TIME_W-1:0] tm;
    insert_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 48 == 0) begin
        case ($urandom_range(0, 2))
          0:       insert_pct = 15;
          1:       insert_pct = 50;
          default: insert_pct = 85;
        endcase
      end
      gaps_on = !(n >= 700 && n < 1100);
      k  = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_REMOVE;
      tm = pick_time();
      issue_word(k, 8'($urandom), 8'($urandom), tm);
      if (k == KIND_INSERT) last_time = tm;
    end
    gaps_on = 1'b1;
  endtask

  // Check each result word against the oldest one queued.
  always @(posedge clk) begin : check_heads
    head_word_t want;
    if (!rst && done) begin
      if (pending_heads.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("%t: unexpected result word: status %0d type %0h purpose %0h time %0h occ %0d",
                   $realtime, status, head_type, head_purpose, head_time, occupancy);
      end else begin
        want = pending_heads.pop_front();
        if (status !== want.status || head_type !== want.ev_type ||
            head_purpose !== want.ev_purpose || head_time !== want.tstamp ||
            occupancy !== want.occupancy) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("%t: result mismatch", $realtime);
            $display("  expected: status %0d type %0h purpose %0h time %0h occ %0d",
                     want.status, want.ev_type, want.ev_purpose, want.tstamp,
                     want.occupancy);
            $display("  actual:   status %0d type %0h purpose %0h time %0h occ %0d",
                     status, head_type, head_purpose, head_time, occupancy);
          end
        end
      end
    end
  end

  // Watchdog: end the run if no word moves either way for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL time_ordered_event_queue_core");
        $finish;
      end
    end
  end

  initial begin
    // Hold every input at a known value from time zero.
    rst            = 1'b1;
    start          = 1'b0;
    kind           = KIND_INSERT;
    event_type     = '0;
    event_purpose  = '0;
    event_time     = '0;
    sched_count    = 0;
    mismatch_count = 0;
    idle_cycles    = 0;
    gaps_on        = 1'b1;
    last_time      = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_remove_empty();
    test_fill_and_overflow();
    test_drain_head();
    test_random_traffic();

    // Drop start, wait out the last result, then allow a few more cycles
    // for any stray word to show up.
    @(negedge clk);
    start <= 1'b0;
    while (pending_heads.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (mismatch_count == 0 && pending_heads.size() == 0) begin
      $display("PASS time_ordered_event_queue_core");
    end else begin
      $display("FAIL time_ordered_event_queue_core");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/toeq_pkg.sv
sv/toeq_cell.sv
sv/time_ordered_event_queue_core.sv
bench/tb_time_ordered_event_queue_core.sv
